FILE: src/tblr_pkg.sv
// shared types and constants for the tile background line renderer
// no dependencies
`default_nettype none

package tblr_pkg;

  localparam int VideoDepth    = 16384;
  localparam int ColourEntries = 32;
  localparam int RowWrapDef    = 224;

  localparam int AddrW   = 14;
  localparam int CidxW   = 5;
  localparam int ColourW = 12;

  localparam logic [AddrW-1:0] NameBaseRst = 14'd14336;

  // input commands
  localparam logic [1:0] CMD_SET_ADDR = 2'd0;
  localparam logic [1:0] CMD_WRITE    = 2'd1;
  localparam logic [1:0] CMD_RENDER   = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_MODE0    = 3'd0;
  localparam logic [2:0] REG_MODE1    = 3'd1;
  localparam logic [2:0] REG_BACKDROP = 3'd2;
  localparam logic [2:0] REG_HSCROLL  = 3'd3;
  localparam logic [2:0] REG_VSCROLL  = 3'd4;
  localparam logic [2:0] REG_NAMEBASE = 3'd5;

  typedef struct packed {
    logic [7:0]       mode0;
    logic [7:0]       mode1;
    logic [3:0]       backdrop;
    logic [7:0]       hscroll;
    logic [7:0]       vscroll;
    logic [AddrW-1:0] name_base;
  } cfg_t;

  // one registered pixel on its way to the result ports
  typedef struct packed {
    logic       valid;
    logic [7:0] px;
    logic       shown;
    logic       prio;
    logic       vis;
    logic       last;
  } pix_t;

endpackage

`default_nettype wire

FILE: src/tblr_vram.sv
// video memory: one write port, one read port with registered data
// depends on tblr_pkg
`default_nettype none

module tblr_vram
  import tblr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] waddr,
  input  wire logic [7:0]       wdata,
  input  wire logic [AddrW-1:0] raddr,
  output logic      [7:0]       rdata
);

  logic [7:0] mem [VideoDepth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/tblr_cram.sv
// colour memory: 32 entries of 12 bits, cleared by reset, registered read
// depends on tblr_pkg
`default_nettype none

module tblr_cram
  import tblr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               we,
  input  wire logic [CidxW-1:0]   waddr,
  input  wire logic [ColourW-1:0] wdata,
  input  wire logic [CidxW-1:0]   raddr,
  output logic      [ColourW-1:0] rdata
);

  logic [ColourW-1:0] mem [ColourEntries];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ColourEntries; k++) begin
        mem[k] <= '0;
      end
    end else if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/tblr_render.sv
// column render sequencer: row reduction, name and bitplane fetches, pixel stage
// depends on tblr_pkg
`default_nettype none

module tblr_render
  import tblr_pkg::*;
#(
  parameter int ROW_WRAP = RowWrapDef
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             go,
  input  wire logic [7:0]       line,
  input  wire logic [4:0]       column,
  input  wire cfg_t             cfg,
  input  wire logic [7:0]       vram_rdata,
  output logic                  busy,
  output logic      [AddrW-1:0] vram_raddr,
  output logic      [CidxW-1:0] cram_raddr,
  output pix_t                  pix_r
);

  localparam logic [8:0] RowWrap = 9'(ROW_WRAP);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MOD   = 7'b0000010,
    S_NAME  = 7'b0000100,
    S_ATTR  = 7'b0001000,
    S_WAIT  = 7'b0010000,
    S_PLANE = 7'b0100000,
    S_PIX   = 7'b1000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [8:0] cur_r;
  logic [7:0] x0_r;
  logic [7:0] line_r;
  logic [4:0] column_r;
  logic [7:0] tile_r;
  logic [7:0] attrib_r;
  logic [7:0] plane_r [4];
  logic [2:0] cnt_r;

  logic [8:0]       sum_start;
  logic [7:0]       hs_start;
  logic [AddrW-1:0] name_addr;
  logic [2:0]       row;
  logic [2:0]       bitsel;
  logic [3:0]       idx;
  logic [7:0]       px;
  logic             drawn;
  logic             shown;
  logic             blank_left;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    if (cfg.mode0[6] && line <= 8'd15) begin
      hs_start = 8'd0;
    end else begin
      hs_start = cfg.hscroll;
    end
    if (column >= 5'd24 && cfg.mode0[7]) begin
      sum_start = {1'b0, line};
    end else begin
      sum_start = {1'b0, line} + {1'b0, cfg.vscroll};
    end
  end

  assign name_addr = cfg.name_base + {3'b0, cur_r[7:3], 6'b0} + {8'b0, column_r, 1'b0};
  assign row       = attrib_r[2] ? ~cur_r[2:0] : cur_r[2:0];

  always_comb begin
    case (state_r)
      S_ATTR:  vram_raddr = name_addr + 14'd1;
      S_PLANE: vram_raddr = {attrib_r[0], tile_r, row, cnt_r[1:0]};
      default: vram_raddr = name_addr;
    endcase
  end

  // pixel datapath
  assign bitsel     = attrib_r[1] ? cnt_r : ~cnt_r;
  assign idx        = {plane_r[3][bitsel], plane_r[2][bitsel],
                       plane_r[1][bitsel], plane_r[0][bitsel]};
  assign px         = x0_r + {5'b0, cnt_r};
  assign drawn      = (line_r >= 8'd24) && (line_r <= 8'd167);
  assign shown      = drawn && cfg.mode1[6];
  assign blank_left = cfg.mode0[5] && (px < 8'd8);
  assign cram_raddr = blank_left ? {1'b1, cfg.backdrop} : {attrib_r[3], idx};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (go) state_nxt = S_MOD;
      end
      S_MOD: begin
        if (cur_r < RowWrap) state_nxt = S_NAME;
      end
      S_NAME:  state_nxt = S_ATTR;
      S_ATTR:  state_nxt = S_WAIT;
      S_WAIT:  state_nxt = S_PLANE;
      S_PLANE: begin
        if (cnt_r == 3'd4) state_nxt = S_PIX;
      end
      S_PIX: begin
        if (cnt_r == 3'd7) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      if (state_r == S_WAIT || (state_r == S_PLANE && cnt_r == 3'd4)) begin
        cnt_r <= '0;
      end else if (state_r == S_PLANE || state_r == S_PIX) begin
        cnt_r <= cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        line_r   <= line;
        column_r <= column;
        x0_r     <= hs_start + {column, 3'b0};
        cur_r    <= sum_start;
      end
      // shared compare and subtract, one step a cycle
      S_MOD: begin
        if (cur_r >= RowWrap) cur_r <= cur_r - RowWrap;
      end
      S_ATTR:  tile_r <= vram_rdata;
      S_WAIT:  attrib_r <= vram_rdata;
      S_PLANE: begin
        if (cnt_r != 3'd0) plane_r[2'(cnt_r - 3'd1)] <= vram_rdata;
      end
      default: ;
    endcase
    pix_r.valid <= rst_n && (state_r == S_PIX);
    pix_r.px    <= px;
    pix_r.shown <= shown;
    pix_r.prio  <= shown && attrib_r[4] && (idx != 4'd0);
    pix_r.vis   <= drawn && (px >= 8'd48) && (px <= 8'd207);
    pix_r.last  <= (cnt_r == 3'd7);
  end

endmodule

`default_nettype wire

FILE: src/tile_background_line_renderer.sv
// Tile background line renderer. Set-address and data-write transactions
// complete in the cycle they are accepted. A render transaction keeps busy
// high through row wrap reduction (one compare and subtract per cycle), the
// name entry reads and the four bitplane reads through the single video
// memory read port, then a pixel phase that emits the eight pixels. Pixels
// leave on out_valid, one per cycle, left to right, each registered from its
// pixel phase state; the receiver cannot stall them. cfg_ready is always
// high; write configuration only idle.
// depends on tblr_pkg, tblr_vram, tblr_cram, tblr_render
`default_nettype none

module tile_background_line_renderer
  import tblr_pkg::*;
#(
  parameter int ROW_WRAP = RowWrapDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_command,
  input  wire logic [AddrW-1:0]   in_address,
  input  wire logic               in_to_colour_ram,
  input  wire logic [7:0]         in_data,
  input  wire logic [7:0]         in_line,
  input  wire logic [4:0]         in_column,
  output logic                    out_valid,
  output logic      [7:0]         out_pixel_x,
  output logic      [ColourW-1:0] out_colour,
  output logic                    out_priority_res,
  output logic                    out_visible,
  output logic                    out_last,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [AddrW-1:0]   cfg_data
);

  cfg_t             cfg_r;
  logic [AddrW-1:0] ptr_r;
  logic             to_cram_r;
  logic [7:0]       latch_r;

  logic             accept;
  logic             wr_cmd;
  logic             vram_we;
  logic             cram_we;
  logic [AddrW-1:0] vram_raddr;
  logic [7:0]       vram_rdata;
  logic [CidxW-1:0] cram_raddr;
  logic [ColourW-1:0] cram_rdata;
  pix_t             pix;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign wr_cmd    = accept && (in_command == CMD_WRITE);
  assign vram_we   = wr_cmd && !to_cram_r;
  assign cram_we   = wr_cmd && to_cram_r && ptr_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode0     <= '0;
      cfg_r.mode1     <= '0;
      cfg_r.backdrop  <= '0;
      cfg_r.hscroll   <= '0;
      cfg_r.vscroll   <= '0;
      cfg_r.name_base <= NameBaseRst;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE0:    cfg_r.mode0     <= cfg_data[7:0];
        REG_MODE1:    cfg_r.mode1     <= cfg_data[7:0];
        REG_BACKDROP: cfg_r.backdrop  <= cfg_data[3:0];
        REG_HSCROLL:  cfg_r.hscroll   <= cfg_data[7:0];
        REG_VSCROLL:  cfg_r.vscroll   <= cfg_data[7:0];
        REG_NAMEBASE: cfg_r.name_base <= cfg_data;
        default: ;
      endcase
    end
  end

  // data port pointer, target and colour latch
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r     <= '0;
      to_cram_r <= 1'b0;
      latch_r   <= '0;
    end else if (accept) begin
      case (in_command)
        CMD_SET_ADDR: begin
          ptr_r     <= in_address;
          to_cram_r <= in_to_colour_ram;
        end
        CMD_WRITE: begin
          if (to_cram_r && !ptr_r[0]) latch_r <= in_data;
          ptr_r <= ptr_r + 14'd1;
        end
        default: ;
      endcase
    end
  end

  tblr_vram u_vram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (ptr_r),
    .wdata (in_data),
    .raddr (vram_raddr),
    .rdata (vram_rdata)
  );

  tblr_cram u_cram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cram_we),
    .waddr (ptr_r[CidxW:1]),
    .wdata ({in_data[3:0], latch_r}),
    .raddr (cram_raddr),
    .rdata (cram_rdata)
  );

  tblr_render #(
    .ROW_WRAP (ROW_WRAP)
  ) u_render (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (accept && (in_command == CMD_RENDER)),
    .line       (in_line),
    .column     (in_column),
    .cfg        (cfg_r),
    .vram_rdata (vram_rdata),
    .busy       (busy),
    .vram_raddr (vram_raddr),
    .cram_raddr (cram_raddr),
    .pix_r      (pix)
  );

  assign out_valid        = pix.valid;
  assign out_pixel_x      = pix.px;
  assign out_colour       = pix.shown ? cram_rdata : '0;
  assign out_priority_res = pix.prio;
  assign out_visible      = pix.vis;
  assign out_last         = pix.last;

endmodule

`default_nettype wire

FILE: sim/tile_background_line_renderer_tb.sv
// self-checking testbench for tile_background_line_renderer: data port writes,
// register programming and column renders checked pixel by pixel against a model
// depends on tblr_pkg and the renderer rtl
`timescale 1ns / 100ps

module tile_background_line_renderer_tb;
  import tblr_pkg::*;

  localparam int HalfPeriod  = 5;
  localparam int RowWrap     = RowWrapDef;
  localparam int DrainCycles = 24;
  localparam int CycleLimit  = 1000000;
  localparam int RoundItems  = 35;

  localparam logic [1:0] CmdUnused = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [13:0] addr;
    logic        tc;
    logic [7:0]  data;
    logic [7:0]  scan;
    logic [4:0]  col;
  } port_item_t;

  typedef struct packed {
    logic [7:0]  x;
    logic [11:0] colour;
    logic        prio;
    logic        vis;
    logic        last;
  } pixel_t;

  // one row of the directed table: a transaction or a register write
  typedef struct packed {
    bit          is_reg;
    logic [2:0]  reg_idx;
    logic [13:0] reg_val;
    port_item_t  it;
    bit          typed;
    logic [7:0]  x_first;
  } script_row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_command;
  logic [AddrW-1:0]  in_address;
  logic              in_to_colour_ram;
  logic [7:0]        in_data;
  logic [7:0]        in_line;
  logic [4:0]        in_column;
  logic              out_valid;
  logic [7:0]        out_pixel_x;
  logic [ColourW-1:0] out_colour;
  logic              out_priority_res;
  logic              out_visible;
  logic              out_last;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [2:0]        cfg_index;
  logic [AddrW-1:0]  cfg_data;

  // mirror of the block's memories, port state and registers
  logic [7:0]  vram_copy [VideoDepth];
  bit          vram_known [VideoDepth];
  logic [11:0] palette_copy [ColourEntries];
  logic [7:0]  palette_latch;
  logic [13:0] port_ptr;
  logic        port_to_palette;
  cfg_t        regs_copy;

  pixel_t      pixels_due [$];
  pixel_t      seen_front;
  script_row_t script [$];

  int unsigned mismatches;
  int unsigned pixels_checked;
  int unsigned items_sent;
  int unsigned renders;
  int unsigned reg_writes;
  int unsigned cycles;
  bit          no_gaps;

  tile_background_line_renderer #(
    .ROW_WRAP(RowWrap)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_address      (in_address),
    .in_to_colour_ram(in_to_colour_ram),
    .in_data         (in_data),
    .in_line         (in_line),
    .in_column       (in_column),
    .out_valid       (out_valid),
    .out_pixel_x     (out_pixel_x),
    .out_colour      (out_colour),
    .out_priority_res(out_priority_res),
    .out_visible     (out_visible),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #HalfPeriod clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d pixels still due", cycles, pixels_due.size());
      $display("tile_background_line_renderer regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model

  function automatic int unsigned scrolled_row(logic [7:0] scan, logic [4:0] col);
    int unsigned v;
    v = scan;
    // right columns may ignore the vertical scroll
    if (!(col >= 5'd24 && regs_copy.mode0[7])) v = v + regs_copy.vscroll;
    return v % RowWrap;
  endfunction

  function automatic logic [13:0] name_entry_addr(logic [7:0] scan, logic [4:0] col);
    int unsigned cur;
    logic [13:0] a;
    cur = scrolled_row(scan, col);
    a = regs_copy.name_base + 14'(((cur >> 3) << 6) + col * 2);
    return a;
  endfunction

  function automatic logic [13:0] plane_base(logic [7:0] scan, logic [4:0] col);
    int unsigned cur;
    logic [13:0] na, na1;
    logic [7:0]  attr;
    logic [2:0]  r;
    cur = scrolled_row(scan, col);
    na = name_entry_addr(scan, col);
    na1 = na + 14'd1;
    attr = vram_copy[na1];
    r = cur[2:0];
    if (attr[2]) r = ~r;
    return {attr[0], vram_copy[na], r, 2'b00};
  endfunction

  function automatic void predict_column(logic [7:0] scan, logic [4:0] col);
    logic [13:0] na1, pb;
    logic [7:0]  attr, x0;
    logic [7:0]  planes [4];
    logic [3:0]  cidx;
    logic [2:0]  b;
    bit          drawn, shown;
    pixel_t      p;
    int          i;
    na1 = name_entry_addr(scan, col) + 14'd1;
    attr = vram_copy[na1];
    pb = plane_base(scan, col);
    for (i = 0; i < 4; i++) planes[i] = vram_copy[pb + 14'(i)];
    x0 = (regs_copy.mode0[6] && scan <= 8'd15) ? 8'd0 : regs_copy.hscroll;
    x0 = x0 + {col, 3'b000};
    drawn = scan >= 8'd24 && scan <= 8'd167;
    shown = drawn && regs_copy.mode1[6];
    for (i = 0; i < 8; i++) begin
      b = attr[1] ? 3'(i) : 3'(7 - i);
      cidx = {planes[3][b], planes[2][b], planes[1][b], planes[0][b]};
      p.x = x0 + 8'(i);
      p.vis = drawn && p.x >= 8'd48 && p.x <= 8'd207;
      p.colour = '0;
      p.prio = 1'b0;
      if (shown) begin
        p.prio = attr[4] && cidx != 4'd0;
        p.colour = palette_copy[{attr[3], cidx}];
        // left column shows the backdrop entry from the sprite half
        if (regs_copy.mode0[5] && p.x < 8'd8) p.colour = palette_copy[{1'b1, regs_copy.backdrop}];
      end
      p.last = (i == 7);
      pixels_due.push_back(p);
    end
  endfunction

  function automatic void apply_item(port_item_t it);
    case (it.cmd)
      CMD_SET_ADDR: begin
        port_ptr = it.addr;
        port_to_palette = it.tc;
      end
      CMD_WRITE: begin
        if (port_to_palette) begin
          if (!port_ptr[0]) palette_latch = it.data;
          else palette_copy[port_ptr[5:1]] = {it.data[3:0], palette_latch};
        end else begin
          vram_copy[port_ptr] = it.data;
          vram_known[port_ptr] = 1'b1;
        end
        port_ptr = port_ptr + 14'd1;
      end
      CMD_RENDER: predict_column(it.scan, it.col);
      default: ;
    endcase
  endfunction

  function automatic void set_reg(logic [2:0] idx, logic [13:0] val);
    case (idx)
      REG_MODE0:    regs_copy.mode0 = val[7:0];
      REG_MODE1:    regs_copy.mode1 = val[7:0];
      REG_BACKDROP: regs_copy.backdrop = val[3:0];
      REG_HSCROLL:  regs_copy.hscroll = val[7:0];
      REG_VSCROLL:  regs_copy.vscroll = val[7:0];
      REG_NAMEBASE: regs_copy.name_base = val;
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pixels_due.size() == 0) begin
        $display("%0t: unexpected pixel x=%0d colour=%03h", $time, out_pixel_x, out_colour);
        mismatches++;
      end else begin
        seen_front = pixels_due.pop_front();
        check_field("pixel_x", 16'(seen_front.x), 16'(out_pixel_x));
        check_field("colour", 16'(seen_front.colour), 16'(out_colour));
        check_field("priority_res", 16'(seen_front.prio), 16'(out_priority_res));
        check_field("visible", 16'(seen_front.vis), 16'(out_visible));
        check_field("last", 16'(seen_front.last), 16'(out_last));
        pixels_checked++;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 45) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(8, 40);
  endfunction

  function automatic port_item_t noise_item(logic [1:0] c);
    port_item_t it;
    it.cmd  = c;
    it.addr = 14'($urandom);
    it.tc   = 1'($urandom);
    it.data = 8'($urandom);
    it.scan = 8'($urandom);
    it.col  = 5'($urandom);
    return it;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic run_item(port_item_t it, bit predict);
    int unsigned gap;
    in_command       <= it.cmd;
    in_address       <= it.addr;
    in_to_colour_ram <= it.tc;
    in_data          <= it.data;
    in_line          <= it.scan;
    in_column        <= it.col;
    start            <= 1'b1;
    do @(posedge clk); while (busy);
    if (predict) apply_item(it);
    if (it.cmd != CmdUnused) items_sent++;
    if (it.cmd == CMD_RENDER) renders++;
    @(negedge clk);
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic go_idle();
    start <= 1'b0;
    while (pixels_due.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [13:0] val, bit more);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    set_reg(idx, val);
    reg_writes++;
    @(negedge clk);
    if (!more) cfg_valid <= 1'b0;
  endtask

  // unused upper bits of the narrow registers carry noise
  task automatic program_regs(logic [7:0] m0, logic [7:0] m1, logic [3:0] bd, logic [7:0] hs,
                              logic [7:0] vs, logic [13:0] nb);
    write_reg(REG_MODE0, {6'($urandom), m0}, 1'b1);
    write_reg(REG_MODE1, {6'($urandom), m1}, 1'b1);
    write_reg(REG_BACKDROP, {10'($urandom), bd}, 1'b1);
    write_reg(REG_HSCROLL, {6'($urandom), hs}, 1'b1);
    write_reg(REG_VSCROLL, {6'($urandom), vs}, 1'b1);
    write_reg(REG_NAMEBASE, nb, 1'b0);
  endtask

  // never let a render read a video byte that was not written
  task automatic touch_vram(logic [13:0] a);
    port_item_t it;
    if (!vram_known[a]) begin
      if (port_ptr != a || port_to_palette) begin
        it = noise_item(CMD_SET_ADDR);
        it.addr = a;
        it.tc = 1'b0;
        run_item(it, 1'b1);
      end
      run_item(noise_item(CMD_WRITE), 1'b1);
    end
  endtask

  task automatic fill_render_sources(logic [7:0] scan, logic [4:0] col);
    logic [13:0] na, pb;
    int          p;
    na = name_entry_addr(scan, col);
    touch_vram(na);
    touch_vram(na + 14'd1);
    pb = plane_base(scan, col);
    for (p = 0; p < 4; p++) touch_vram(pb + 14'(p));
  endtask

  task automatic random_burst();
    port_item_t  it;
    int unsigned pick, n, k;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      it = noise_item(CMD_RENDER);
      if ($urandom_range(0, 2) != 0) it.scan = 8'($urandom_range(24, 167));
      fill_render_sources(it.scan, it.col);
      run_item(it, 1'b1);
    end else if (pick < 80) begin
      // address set followed by a burst of data writes
      it = noise_item(CMD_SET_ADDR);
      it.tc = pick < 60;
      if (!it.tc && pick < 70) it.addr = regs_copy.name_base + 14'($urandom_range(0, 1791));
      run_item(it, 1'b1);
      n = $urandom_range(1, 8);
      for (k = 0; k < n; k++) run_item(noise_item(CMD_WRITE), 1'b1);
    end else if (pick < 88) begin
      run_item(noise_item(CMD_WRITE), 1'b1);
    end else if (pick < 95) begin
      run_item(noise_item(CmdUnused), 1'b1);
    end else begin
      run_item(noise_item(CMD_SET_ADDR), 1'b1);
    end
  endtask

  function automatic script_row_t cmd_row(logic [1:0] c, logic [13:0] a, logic t, logic [7:0] d,
                                          logic [7:0] scan, logic [4:0] col);
    script_row_t r;
    r = '0;
    r.it = '{cmd: c, addr: a, tc: t, data: d, scan: scan, col: col};
    return r;
  endfunction

  // render whose pixels are all dark and hidden; only pixel_x moves
  function automatic script_row_t blank_row(logic [7:0] scan, logic [4:0] col, logic [7:0] xf);
    script_row_t r;
    r = cmd_row(CMD_RENDER, 14'd0, 1'b0, 8'd0, scan, col);
    r.typed = 1'b1;
    r.x_first = xf;
    return r;
  endfunction

  function automatic script_row_t reg_row(logic [2:0] idx, logic [13:0] val);
    script_row_t r;
    r = '0;
    r.is_reg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  initial begin
    int unsigned round, round_start, i;
    logic [7:0]  mode1_pick;
    pixel_t      p;

    rst_n = 1'b0;
    start = 1'b0;
    in_command = CMD_SET_ADDR;
    in_address = '0;
    in_to_colour_ram = 1'b0;
    in_data = '0;
    in_line = '0;
    in_column = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_MODE0;
    cfg_data = '0;
    mismatches = 0;
    pixels_checked = 0;
    items_sent = 0;
    renders = 0;
    reg_writes = 0;
    cycles = 0;
    no_gaps = 1'b0;
    palette_latch = '0;
    port_ptr = '0;
    port_to_palette = 1'b0;
    foreach (palette_copy[k]) palette_copy[k] = '0;
    regs_copy = '{mode0: 8'd0, mode1: 8'd0, backdrop: 4'd0, hscroll: 8'd0, vscroll: 8'd0,
                  name_base: NameBaseRst};

    // directed table: reset state, pointer wrap, palette pairing, register extremes
    script.push_back(blank_row(8'd0, 5'd0, 8'd0));
    script.push_back(blank_row(8'd255, 5'd31, 8'd248));
    script.push_back(cmd_row(CmdUnused, 14'h3FFF, 1'b1, 8'hFF, 8'hFF, 5'd31));
    script.push_back(cmd_row(CMD_SET_ADDR, 14'h3FFF, 1'b0, 8'h00, 8'h00, 5'd0));
    script.push_back(cmd_row(CMD_WRITE, 14'h0000, 1'b0, 8'hFF, 8'h00, 5'd0));
    script.push_back(cmd_row(CMD_WRITE, 14'h0000, 1'b0, 8'h00, 8'h00, 5'd0));
    script.push_back(cmd_row(CMD_SET_ADDR, 14'h0020, 1'b1, 8'h00, 8'h00, 5'd0));
    script.push_back(cmd_row(CMD_WRITE, 14'h0000, 1'b0, 8'hA5, 8'h00, 5'd0));
    script.push_back(cmd_row(CMD_WRITE, 14'h0000, 1'b0, 8'hFF, 8'h00, 5'd0));
    script.push_back(cmd_row(CMD_WRITE, 14'h0000, 1'b0, 8'h3C, 8'h00, 5'd0));
    script.push_back(cmd_row(CMD_WRITE, 14'h0000, 1'b0, 8'h07, 8'h00, 5'd0));
    script.push_back(cmd_row(CMD_SET_ADDR, 14'h3FFE, 1'b1, 8'h00, 8'h00, 5'd0));
    script.push_back(cmd_row(CMD_WRITE, 14'h0000, 1'b0, 8'h5A, 8'h00, 5'd0));
    script.push_back(cmd_row(CMD_WRITE, 14'h0000, 1'b0, 8'hF3, 8'h00, 5'd0));
    script.push_back(reg_row(REG_MODE1, 14'h0040));
    script.push_back(blank_row(8'd20, 5'd3, 8'd24));
    script.push_back(reg_row(REG_MODE0, 14'h00E0));
    script.push_back(reg_row(REG_BACKDROP, 14'h0001));
    script.push_back(reg_row(REG_HSCROLL, 14'h00FF));
    script.push_back(reg_row(REG_VSCROLL, 14'h00FF));
    script.push_back(reg_row(REG_NAMEBASE, 14'h3FFF));
    script.push_back(blank_row(8'd15, 5'd31, 8'd248));
    script.push_back(cmd_row(CMD_RENDER, 14'h0000, 1'b0, 8'h00, 8'd24, 5'd0));
    script.push_back(cmd_row(CMD_RENDER, 14'h0000, 1'b0, 8'h00, 8'd167, 5'd24));
    script.push_back(blank_row(8'd168, 5'd0, 8'd255));
    script.push_back(cmd_row(CMD_RENDER, 14'h0000, 1'b0, 8'h00, 8'd100, 5'd5));
    script.push_back(reg_row(REG_MODE1, 14'h00BF));
    script.push_back(cmd_row(CMD_RENDER, 14'h0000, 1'b0, 8'h00, 8'd100, 5'd10));
    script.push_back(reg_row(REG_MODE0, 14'h0000));
    script.push_back(reg_row(REG_MODE1, 14'h00FF));
    script.push_back(reg_row(REG_BACKDROP, 14'h000F));
    script.push_back(reg_row(REG_HSCROLL, 14'h0000));
    script.push_back(reg_row(REG_VSCROLL, 14'h0000));
    script.push_back(reg_row(REG_NAMEBASE, 14'h0000));
    script.push_back(cmd_row(CMD_RENDER, 14'h0000, 1'b0, 8'h00, 8'd167, 5'd31));
    script.push_back(cmd_row(CMD_RENDER, 14'h0000, 1'b0, 8'h00, 8'd24, 5'd6));

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[k]) begin
      if (script[k].is_reg) begin
        if (k == 0 || !script[k-1].is_reg) go_idle();
        write_reg(script[k].reg_idx, script[k].reg_val,
                  k + 1 < script.size() && script[k+1].is_reg);
      end else begin
        if (script[k].it.cmd == CMD_RENDER) fill_render_sources(script[k].it.scan, script[k].it.col);
        if (script[k].typed) begin
          for (i = 0; i < 8; i++) begin
            p.x = script[k].x_first + 8'(i);
            p.colour = '0;
            p.prio = 1'b0;
            p.vis = 1'b0;
            p.last = (i == 7);
            pixels_due.push_back(p);
          end
        end
        run_item(script[k].it, !script[k].typed);
      end
    end

    // random rounds, each under its own register setting
    for (round = 0; round < 6; round++) begin
      go_idle();
      case (round)
        0: program_regs(8'h00, 8'h40, 4'h0, 8'h00, 8'h00, 14'h0000);
        1: program_regs(8'hFF, 8'hFF, 4'hF, 8'hFF, 8'hFF, 14'h3FFF);
        default: begin
          mode1_pick = 8'($urandom);
          if ($urandom_range(0, 3) != 0) mode1_pick[6] = 1'b1;
          program_regs(8'($urandom), mode1_pick, 4'($urandom), 8'($urandom), 8'($urandom),
                       ($urandom_range(0, 1) != 0) ? NameBaseRst : 14'($urandom));
        end
      endcase
      no_gaps = (round == 3);
      round_start = items_sent;
      while (items_sent - round_start < RoundItems) random_burst();
    end

    no_gaps = 1'b0;
    go_idle();
    $display("ran %0d transactions with %0d column renders and %0d register writes",
             items_sent, renders, reg_writes);
    $display("compared %0d pixels, %0d mismatches", pixels_checked, mismatches);
    if (mismatches == 0) begin
      $display("tile_background_line_renderer regression: pass");
    end else begin
      $display("tile_background_line_renderer regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
src/tblr_pkg.sv
src/tblr_vram.sv
src/tblr_cram.sv
src/tblr_render.sv
src/tile_background_line_renderer.sv
sim/tile_background_line_renderer_tb.sv
